>>> src/gfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfr_pkg
// Types and constants shared by the geofence rectangle point filter.
// ----------------------------------------------------------------------------
package gfr_pkg;

   localparam int LAT_W     = 28;
   localparam int LON_W     = 30;
   localparam int LON_N_W   = 29;
   localparam int TIME_W    = 32;
   localparam int INDEX_W   = 6;
   localparam int LON_EXT_W = 31;

   localparam logic signed [LON_EXT_W-1:0] LON_HALF_TURN = 31'sd180000000;
   localparam logic signed [LON_EXT_W-1:0] LON_FULL_TURN = 31'sd360000000;

   localparam logic FUNC_WRITE_TILE = 1'b0;
   localparam logic FUNC_TEST_POINT = 1'b1;

   typedef enum logic [2:0] {
      GFR_IDLE,
      GFR_WRITE,
      GFR_SCAN,
      GFR_DRAIN,
      GFR_DONE
   } gfr_state_type;

   typedef struct packed {
      logic signed [LAT_W-1:0]   lat_lo;
      logic signed [LAT_W-1:0]   lat_hi;
      logic signed [LON_N_W-1:0] lon_west;
      logic signed [LON_N_W-1:0] lon_east;
   } gfr_entry_type;

   typedef struct packed {
      logic valid;
      logic allowed;
   } gfr_flags_type;

   // Folds any 30-bit longitude into [-180, 180) degrees. One turn up or down
   // always suffices for the 30-bit input range.
   function automatic logic signed [LON_N_W-1:0] wrap_lon(
      input logic signed [LON_W-1:0] lon
   );
      logic signed [LON_EXT_W-1:0] x;
      logic signed [LON_EXT_W-1:0] r;
      x = LON_EXT_W'(lon);
      if (x < -LON_HALF_TURN) begin
         r = x + LON_FULL_TURN;
      end else if (x >= LON_HALF_TURN) begin
         r = x - LON_FULL_TURN;
      end else begin
         r = x;
      end
      return r[LON_N_W-1:0];
   endfunction

endpackage

>>> src/geofence_rectangle_point_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geofence_rectangle_point_filter
// Passes point transactions that fall inside a stored rectangular tile.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one transaction per accepted cycle (req_valid
//   high, req_stall low). req_func selects a tile write or a point test.
//   A tile write stores normalized bounds and flags; writes to an index at
//   or beyond TILE_COUNT are dropped. It stalls the input while the entry is
//   written in the WRITE state, so the next request waits for that write.
//   A point test scans every table entry through one comparator set, one
//   entry per cycle from the memory read port in SCAN, then DRAIN and DONE;
//   req_stall stays high until the scan is done and any hit is loaded, so
//   a point test waits for the last one. A hit is on the rsp_ channel in the
//   same cycle that the stall ends. A miss produces no transaction.
//   The rsp_ output is registered, so the next request is taken while a
//   result waits; if rsp_stall holds a previous result when a new hit is
//   ready, the scan result waits until the output register frees.
//   csr_ carries the allow-list enable; it is always ready and is meant to
//   be written while no transaction is in flight.
//   Synchronous reset clears all tile valid flags, the enable and the
//   output valid; tile bounds are left as they are.
// ----------------------------------------------------------------------------
module geofence_rectangle_point_filter #(
   parameter int TILE_COUNT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [gfr_pkg::INDEX_W-1:0]         req_tile_index,
   input  logic signed [gfr_pkg::LAT_W-1:0]    req_tile_lat_min,
   input  logic signed [gfr_pkg::LAT_W-1:0]    req_tile_lat_max,
   input  logic signed [gfr_pkg::LON_W-1:0]    req_tile_lon_min,
   input  logic signed [gfr_pkg::LON_W-1:0]    req_tile_lon_max,
   input  logic                                req_tile_allowed,
   input  logic signed [gfr_pkg::LAT_W-1:0]    req_point_lat,
   input  logic signed [gfr_pkg::LON_W-1:0]    req_point_lon,
   input  logic [gfr_pkg::TIME_W-1:0]          req_point_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gfr_pkg::TIME_W-1:0]          rsp_out_time,
   output logic signed [gfr_pkg::LAT_W-1:0]    rsp_out_lat,
   output logic signed [gfr_pkg::LON_W-1:0]    rsp_out_lon,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_use_allow_list
);
   import gfr_pkg::*;

   // Only the first 64 entries can ever be addressed by the index field.
   localparam int DEPTH  = (TILE_COUNT < 64) ? TILE_COUNT : 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [INDEX_W:0]  INDEX_LIMIT = (INDEX_W + 1)'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);

   gfr_state_type state_ff, state_in;

   logic                      allow_en_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic                      rd_issue_ff;
   logic                      hit_ff;
   logic                      wr_keep_ff;
   logic [ADDR_W-1:0]         wr_addr_ff;
   gfr_entry_type             wr_entry_ff;
   logic                      wr_allowed_ff;
   logic signed [LAT_W-1:0]   pt_lat_ff;
   logic signed [LON_W-1:0]   pt_lon_ff;
   logic signed [LON_N_W-1:0] pt_lon_n_ff;
   logic [TIME_W-1:0]         pt_time_ff;
   logic                      rsp_valid_ff;
   logic [TIME_W-1:0]         rsp_time_ff;
   logic signed [LAT_W-1:0]   rsp_lat_ff;
   logic signed [LON_W-1:0]   rsp_lon_ff;

   logic          req_accept;
   logic          rsp_accept;
   logic          rsp_load;
   logic          rd_en;
   logic          wr_en;
   logic          entry_hit;
   gfr_entry_type rd_entry;
   gfr_flags_type rd_flags;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GFR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         GFR_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = (req_func == FUNC_TEST_POINT) ? GFR_SCAN : GFR_WRITE;
            end
         end
         GFR_WRITE: begin
            wr_en    = wr_keep_ff;
            state_in = GFR_IDLE;
         end
         GFR_SCAN: begin
            rd_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = GFR_DRAIN;
            end
         end
         GFR_DRAIN: begin
            state_in = GFR_DONE;
         end
         GFR_DONE: begin
            if (!hit_ff) begin
               state_in = GFR_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = GFR_IDLE;
            end
         end
         default: begin
            state_in = GFR_IDLE;
         end
      endcase
   end

   // Control registers of the scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_en_ff  <= 1'b0;
         addr_ff      <= '0;
         rd_issue_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            allow_en_ff <= csr_use_allow_list;
         end
         rd_issue_ff <= rd_en;
         if (req_accept) begin
            addr_ff <= '0;
            hit_ff  <= 1'b0;
         end else begin
            if (rd_en) begin
               addr_ff <= addr_ff + 1'b1;
            end
            // Read data arrives in the cycle after its address, as rd_issue_ff marks.
            if (rd_issue_ff && entry_hit) begin
               hit_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_keep_ff <= 1'b0;
      end else if (req_accept) begin
         wr_keep_ff <= ({1'b0, req_tile_index} < INDEX_LIMIT);
      end
   end

   // Captured transaction fields; normalization happens on capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         wr_addr_ff           <= req_tile_index[ADDR_W-1:0];
         wr_entry_ff.lat_lo   <= req_tile_lat_min;
         wr_entry_ff.lat_hi   <= req_tile_lat_max;
         wr_entry_ff.lon_west <= wrap_lon(req_tile_lon_min);
         wr_entry_ff.lon_east <= wrap_lon(req_tile_lon_max);
         wr_allowed_ff        <= req_tile_allowed;
         pt_lat_ff            <= req_point_lat;
         pt_lon_ff            <= req_point_lon;
         pt_lon_n_ff          <= wrap_lon(req_point_lon);
         pt_time_ff           <= req_point_time;
      end
      if (rsp_load) begin
         rsp_time_ff <= pt_time_ff;
         rsp_lat_ff  <= pt_lat_ff;
         rsp_lon_ff  <= pt_lon_ff;
      end
   end

   gfr_tile_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_tile_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr_ff),
      .wr_entry   (wr_entry_ff),
      .wr_allowed (wr_allowed_ff),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .rd_entry   (rd_entry),
      .rd_flags   (rd_flags)
   );

   gfr_cmp_unit u_cmp_unit (
      .entry    (rd_entry),
      .flags    (rd_flags),
      .allow_en (allow_en_ff),
      .pt_lat   (pt_lat_ff),
      .pt_lon_n (pt_lon_n_ff),
      .hit      (entry_hit)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_time = rsp_time_ff;
   assign rsp_out_lat  = rsp_lat_ff;
   assign rsp_out_lon  = rsp_lon_ff;

   a_point_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == FUNC_TEST_POINT) |=> state_ff == GFR_SCAN)
      else $error("point transaction did not start a scan");

   a_tile_goes_write: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == FUNC_WRITE_TILE) |=> state_ff == GFR_WRITE)
      else $error("tile transaction did not enter the write state");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_issue_ff |-> (state_ff == GFR_SCAN) || (state_ff == GFR_DRAIN))
      else $error("read data pending outside the scan");

   a_result_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> hit_ff && (state_ff == GFR_DONE))
      else $error("result loaded without a hit");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GFR_SCAN) |-> !wr_en && req_stall)
      else $error("write or accept during a scan");

endmodule

>>> src/gfr_tile_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfr_tile_mem
// Tile bound memory with one write and one registered read port, plus
// valid and allowed flags held in flops; reset clears the valid flags.
// ----------------------------------------------------------------------------
module gfr_tile_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  gfr_pkg::gfr_entry_type wr_entry,
   input  logic                   wr_allowed,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output gfr_pkg::gfr_entry_type rd_entry,
   output gfr_pkg::gfr_flags_type rd_flags
);
   import gfr_pkg::*;

   gfr_entry_type mem [DEPTH];
   logic          valid_ff   [DEPTH];
   logic          allowed_ff [DEPTH];
   gfr_entry_type rd_entry_ff;
   gfr_flags_type rd_flags_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         allowed_ff[wr_addr] <= wr_allowed;
      end
      if (rd_en) begin
         rd_flags_ff.valid   <= valid_ff[rd_addr];
         rd_flags_ff.allowed <= allowed_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_flags = rd_flags_ff;

endmodule

>>> src/gfr_cmp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfr_cmp_unit
// Shared comparator set: decides whether one tile entry holds the point.
// ----------------------------------------------------------------------------
module gfr_cmp_unit (
   input  gfr_pkg::gfr_entry_type             entry,
   input  gfr_pkg::gfr_flags_type             flags,
   input  logic                               allow_en,
   input  logic signed [gfr_pkg::LAT_W-1:0]   pt_lat,
   input  logic signed [gfr_pkg::LON_N_W-1:0] pt_lon_n,
   output logic                               hit
);
   import gfr_pkg::*;

   logic lat_in;
   logic above_west;
   logic below_east;
   logic lon_in;
   logic eligible;

   always_comb begin
      lat_in     = (pt_lat >= entry.lat_lo) && (pt_lat <= entry.lat_hi);
      above_west = pt_lon_n >= entry.lon_west;
      below_east = pt_lon_n <= entry.lon_east;
      // A tile whose west bound lies east of its east bound spans the antimeridian.
      if (entry.lon_west <= entry.lon_east) begin
         lon_in = above_west && below_east;
      end else begin
         lon_in = above_west || below_east;
      end
      eligible = flags.valid && (!allow_en || flags.allowed);
      hit      = eligible && lat_in && lon_in;
   end

endmodule

>>> tb/sv/geofence_rectangle_point_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geofence_rectangle_point_filter_tb
// Self-checking testbench for the rectangular geofence point filter. Tile
// writes and point tests are driven in random bursts against a receiver that
// stalls in changing patterns. A scoreboard keeps its own tile table and
// predicts which points pass. Every passed point is compared field by field
// in order. Directed corner cases come first, then random phases with the
// allow list alternately off and on.
// ----------------------------------------------------------------------------
module geofence_rectangle_point_filter_tb;
   import gfr_pkg::*;

   localparam int     TILE_COUNT     = 64;
   localparam longint HALF_TURN      = 180000000;
   localparam longint FULL_TURN      = 360000000;
   localparam longint LAT_LIMIT      = 90000000;
   localparam longint LON_RAW_MAX    = 536870911;
   localparam longint LON_RAW_MIN    = -536870912;
   localparam int     IDLE_HOLD      = 100;
   localparam int     RANDOM_PHASES  = 6;
   localparam int     DRAIN_LIMIT    = 200000;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BURSTY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct {
      logic                      func;
      logic [INDEX_W-1:0]        tile_index;
      logic signed [LAT_W-1:0]   lat_min;
      logic signed [LAT_W-1:0]   lat_max;
      logic signed [LON_W-1:0]   lon_min;
      logic signed [LON_W-1:0]   lon_max;
      logic                      allowed;
      logic signed [LAT_W-1:0]   point_lat;
      logic signed [LON_W-1:0]   point_lon;
      logic [TIME_W-1:0]         point_time;
   } geo_request_type;

   typedef struct {
      logic [TIME_W-1:0]         stamp;
      logic signed [LAT_W-1:0]   lat;
      logic signed [LON_W-1:0]   lon;
   } passed_point_type;

   // Keeps a private copy of the tile table and the allow-list enable, and
   // holds the points that are predicted to pass, oldest first.
   class geofence_scoreboard;
      longint           south[TILE_COUNT];
      longint           north[TILE_COUNT];
      longint           west[TILE_COUNT];
      longint           east[TILE_COUNT];
      bit               occupied[TILE_COUNT];
      bit               permitted[TILE_COUNT];
      bit               allow_only;
      passed_point_type passed_queue[$];
      int               errors;
      int               tile_writes;
      int               point_tests;
      int               points_checked;

      function new();
         int i;
         for (i = 0; i < TILE_COUNT; i++) begin
            south[i]     = 0;
            north[i]     = 0;
            west[i]      = 0;
            east[i]      = 0;
            occupied[i]  = 1'b0;
            permitted[i] = 1'b0;
         end
         allow_only     = 1'b0;
         errors         = 0;
         tile_writes    = 0;
         point_tests    = 0;
         points_checked = 0;
      endfunction

      // Folds a longitude into [-180, 180) degrees by a true modulo.
      static function longint fold_lon(longint lon);
         longint m;
         m = (lon + HALF_TURN) % FULL_TURN;
         if (m < 0) begin
            m = m + FULL_TURN;
         end
         return m - HALF_TURN;
      endfunction

      function void set_allow_list(bit enable);
         allow_only = enable;
      endfunction

      function int pending();
         return passed_queue.size();
      endfunction

      function bit tile_contains(int t, longint lat, longint lon_n);
         if (lat < south[t] || lat > north[t]) begin
            return 1'b0;
         end
         // A west bound above the east bound means the tile spans the antimeridian.
         if (west[t] <= east[t]) begin
            return (lon_n >= west[t]) && (lon_n <= east[t]);
         end
         return (lon_n >= west[t]) || (lon_n <= east[t]);
      endfunction

      function void note_request(geo_request_type r);
         int               t;
         longint           lat;
         longint           lon_n;
         bit               hit;
         passed_point_type p;
         if (r.func == FUNC_WRITE_TILE) begin
            t = int'(r.tile_index);
            tile_writes++;
            if (t < TILE_COUNT) begin
               south[t]     = r.lat_min;
               north[t]     = r.lat_max;
               west[t]      = fold_lon(r.lon_min);
               east[t]      = fold_lon(r.lon_max);
               occupied[t]  = 1'b1;
               permitted[t] = r.allowed;
            end
         end else begin
            point_tests++;
            lat   = r.point_lat;
            lon_n = fold_lon(r.point_lon);
            hit   = 1'b0;
            for (t = 0; t < TILE_COUNT && !hit; t++) begin
               if (occupied[t] && (!allow_only || permitted[t]) &&
                   tile_contains(t, lat, lon_n)) begin
                  hit = 1'b1;
               end
            end
            if (hit) begin
               p.stamp = r.point_time;
               p.lat   = r.point_lat;
               p.lon   = r.point_lon;
               passed_queue.push_back(p);
            end
         end
      endfunction

      function void check_result(logic [TIME_W-1:0] stamp, logic signed [LAT_W-1:0] lat,
                                 logic signed [LON_W-1:0] lon);
         passed_point_type p;
         if (passed_queue.size() == 0) begin
            $error("Unexpected result transaction: time %0d lat %0d lon %0d",
                   stamp, lat, lon);
            errors++;
            return;
         end
         p = passed_queue.pop_front();
         points_checked++;
         if (stamp !== p.stamp) begin
            $error("out_time mismatch: expected %0d, actual %0d", p.stamp, stamp);
            errors++;
         end
         if (lat !== p.lat) begin
            $error("out_lat mismatch: expected %0d, actual %0d", p.lat, lat);
            errors++;
         end
         if (lon !== p.lon) begin
            $error("out_lon mismatch: expected %0d, actual %0d", p.lon, lon);
            errors++;
         end
      endfunction
   endclass

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_stall;
   logic                      req_func           = 1'b0;
   logic [INDEX_W-1:0]        req_tile_index     = '0;
   logic signed [LAT_W-1:0]   req_tile_lat_min   = '0;
   logic signed [LAT_W-1:0]   req_tile_lat_max   = '0;
   logic signed [LON_W-1:0]   req_tile_lon_min   = '0;
   logic signed [LON_W-1:0]   req_tile_lon_max   = '0;
   logic                      req_tile_allowed   = 1'b0;
   logic signed [LAT_W-1:0]   req_point_lat      = '0;
   logic signed [LON_W-1:0]   req_point_lon      = '0;
   logic [TIME_W-1:0]         req_point_time     = '0;
   logic                      rsp_valid;
   logic                      rsp_stall          = 1'b0;
   logic [TIME_W-1:0]         rsp_out_time;
   logic signed [LAT_W-1:0]   rsp_out_lat;
   logic signed [LON_W-1:0]   rsp_out_lon;
   logic                      csr_valid          = 1'b0;
   logic                      csr_ready;
   logic                      csr_use_allow_list = 1'b0;

   geofence_scoreboard sb;

   // Stimulus-side copy of the table, used to aim points at tiles and in the initial table fill.
   longint shadow_south[TILE_COUNT];
   longint shadow_north[TILE_COUNT];
   longint shadow_west[TILE_COUNT];
   longint shadow_east[TILE_COUNT];
   bit     shadow_allowed[TILE_COUNT];
   bit     cur_allow   = 1'b0;
   int     burst_left  = 0;

   geofence_rectangle_point_filter #(
      .TILE_COUNT(TILE_COUNT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_tile_index     (req_tile_index),
      .req_tile_lat_min   (req_tile_lat_min),
      .req_tile_lat_max   (req_tile_lat_max),
      .req_tile_lon_min   (req_tile_lon_min),
      .req_tile_lon_max   (req_tile_lon_max),
      .req_tile_allowed   (req_tile_allowed),
      .req_point_lat      (req_point_lat),
      .req_point_lon      (req_point_lon),
      .req_point_time     (req_point_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_time       (rsp_out_time),
      .rsp_out_lat        (rsp_out_lat),
      .rsp_out_lon        (rsp_out_lon),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_use_allow_list (csr_use_allow_list)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: the pattern changes whenever a random span runs out.
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;
   int             stall_run  = 0;
   int             stall_tick = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(40, 400);
      end else begin
         stall_span = stall_span - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_BURSTY: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 20);
               rsp_stall <= ~rsp_stall;
            end else begin
               stall_run = stall_run - 1;
            end
         end
         default: rsp_stall <= ((stall_tick % 5) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_result(rsp_out_time, rsp_out_lat, rsp_out_lon);
      end
   end

   function automatic longint pick(longint lo, longint hi);
      bit [63:0] raw;
      longint    span;
      if (hi <= lo) begin
         return lo;
      end
      span = hi - lo + 1;
      raw  = {$urandom(), $urandom()};
      return lo + longint'(raw % span);
   endfunction

   function automatic longint raw_lat();
      logic signed [LAT_W-1:0] v;
      v = LAT_W'($urandom());
      return v;
   endfunction

   function automatic longint raw_lon();
      logic signed [LON_W-1:0] v;
      v = LON_W'($urandom());
      return v;
   endfunction

   // Every field gets a random value so that unused fields toggle as well.
   function automatic geo_request_type random_request();
      geo_request_type r;
      r.func       = 1'($urandom());
      r.tile_index = INDEX_W'($urandom());
      r.lat_min    = LAT_W'($urandom());
      r.lat_max    = LAT_W'($urandom());
      r.lon_min    = LON_W'($urandom());
      r.lon_max    = LON_W'($urandom());
      r.allowed    = 1'($urandom());
      r.point_lat  = LAT_W'($urandom());
      r.point_lon  = LON_W'($urandom());
      r.point_time = $urandom();
      return r;
   endfunction

   // Presents one transaction in the current burst and waits until it is taken.
   task automatic drive_request(input geo_request_type r);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_func         <= r.func;
      req_tile_index   <= r.tile_index;
      req_tile_lat_min <= r.lat_min;
      req_tile_lat_max <= r.lat_max;
      req_tile_lon_min <= r.lon_min;
      req_tile_lon_max <= r.lon_max;
      req_tile_allowed <= r.allowed;
      req_point_lat    <= r.point_lat;
      req_point_lon    <= r.point_lon;
      req_point_time   <= r.point_time;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic release_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      release_requests();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // A missed point leaves no result, so hold a full scan time after draining.
   task automatic wait_idle();
      wait_drained();
      repeat (IDLE_HOLD) @(posedge clock);
   endtask

   task automatic write_allow_list(input bit enable);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_use_allow_list <= enable;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_allow_list(enable);
      cur_allow = enable;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_tile(input int idx, input longint lo, input longint hi,
                            input longint w, input longint e, input bit allowed);
      geo_request_type r;
      r = random_request();
      r.func       = FUNC_WRITE_TILE;
      r.tile_index = idx[INDEX_W-1:0];
      r.lat_min    = lo[LAT_W-1:0];
      r.lat_max    = hi[LAT_W-1:0];
      r.lon_min    = w[LON_W-1:0];
      r.lon_max    = e[LON_W-1:0];
      r.allowed    = allowed;
      shadow_south[idx]   = r.lat_min;
      shadow_north[idx]   = r.lat_max;
      shadow_west[idx]    = geofence_scoreboard::fold_lon(r.lon_min);
      shadow_east[idx]    = geofence_scoreboard::fold_lon(r.lon_max);
      shadow_allowed[idx] = allowed;
      drive_request(r);
   endtask

   task automatic send_point(input longint lat, input longint lon,
                             input logic [TIME_W-1:0] stamp);
      geo_request_type r;
      r = random_request();
      r.func       = FUNC_TEST_POINT;
      r.point_lat  = lat[LAT_W-1:0];
      r.point_lon  = lon[LON_W-1:0];
      r.point_time = stamp;
      drive_request(r);
   endtask

   task automatic random_tile();
      longint lo;
      longint hi;
      longint w;
      longint e;
      int     idx;
      idx = $urandom_range(0, TILE_COUNT - 1);
      w   = pick(-FULL_TURN, FULL_TURN - 1);
      e   = pick(-FULL_TURN, FULL_TURN - 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            lo = pick(-LAT_LIMIT, LAT_LIMIT);
            hi = pick(lo, LAT_LIMIT);
         end
         4, 5: begin
            lo = pick(-LAT_LIMIT, LAT_LIMIT - 200000);
            hi = lo + pick(0, 200000);
            e  = w + pick(0, 3000000);
         end
         6: begin
            lo = pick(-LAT_LIMIT + 1000000, LAT_LIMIT);
            hi = lo - pick(1, 1000000);
         end
         7: begin
            lo = pick(-LAT_LIMIT, LAT_LIMIT);
            hi = lo;
            e  = w;
         end
         8: begin
            lo = raw_lat();
            hi = raw_lat();
            w  = raw_lon();
            e  = raw_lon();
         end
         default: begin
            lo = pick(-LAT_LIMIT, 0);
            hi = pick(0, LAT_LIMIT);
         end
      endcase
      send_tile(idx, lo, hi, w, e, 1'($urandom()));
   endtask

   // Most points are aimed into a stored tile, on its bounds or just past them.
   task automatic random_point();
      longint lat;
      longint lon_n;
      longint lon;
      longint lo;
      longint hi;
      longint w;
      longint e;
      int     t;
      int     tries;
      bit     found;
      found = 1'b0;
      t     = 0;
      if ($urandom_range(0, 9) < 6) begin
         for (tries = 0; tries < 12 && !found; tries++) begin
            t = $urandom_range(0, TILE_COUNT - 1);
            if (shadow_south[t] <= shadow_north[t] &&
                (!cur_allow || shadow_allowed[t] || tries > 8)) begin
               found = 1'b1;
            end
         end
      end
      if (found) begin
         lo = shadow_south[t];
         hi = shadow_north[t];
         w  = shadow_west[t];
         e  = shadow_east[t];
         case ($urandom_range(0, 3))
            0: lat = lo;
            1: lat = hi;
            default: lat = pick(lo, hi);
         endcase
         if (w <= e) begin
            case ($urandom_range(0, 3))
               0: lon_n = w;
               1: lon_n = e;
               default: lon_n = pick(w, e);
            endcase
         end else if ($urandom_range(0, 1) == 1) begin
            lon_n = pick(w, HALF_TURN - 1);
         end else begin
            lon_n = pick(-HALF_TURN, e);
         end
         case ($urandom_range(0, 7))
            0: lat = hi + 1;
            1: lon_n = e + 1;
            default: ;
         endcase
         lon = lon_n;
         case ($urandom_range(0, 3))
            2: if (lon + FULL_TURN <= LON_RAW_MAX) lon = lon + FULL_TURN;
            3: if (lon - FULL_TURN >= LON_RAW_MIN) lon = lon - FULL_TURN;
            default: ;
         endcase
      end else if ($urandom_range(0, 4) == 0) begin
         lat = raw_lat();
         lon = raw_lon();
      end else begin
         lat = pick(-LAT_LIMIT, LAT_LIMIT);
         lon = pick(-FULL_TURN, FULL_TURN - 1);
      end
      send_point(lat, lon, $urandom());
   endtask

   initial begin
      int i;
      int phase_num;
      int item_num;
      int item_total;
      int wait_cycles;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_allow_list(1'b0);

      // Every entry is written before the first scan so that no scan reads
      // bounds that were never stored. These tiles have south above north.
      for (i = 0; i < TILE_COUNT; i++) begin
         send_tile(i, pick(-80000000, LAT_LIMIT), 0, pick(-FULL_TURN, FULL_TURN - 1),
                   pick(-FULL_TURN, FULL_TURN - 1), 1'($urandom()));
         send_tile(i, shadow_south[i], shadow_south[i] - pick(1, 5000000),
                   raw_lon(), raw_lon(), 1'($urandom()));
      end

      // Plain tile, corners inclusive, one step outside, longitude a turn away.
      send_tile(1, 10000000, 20000000, 30000000, 40000000, 1'b1);
      send_point(10000000, 30000000, '0);
      send_point(20000000, 40000000, '1);
      send_point(20000001, 35000000, $urandom());
      send_point(15000000, 40000001, $urandom());
      send_point(15000000, 390000000, $urandom());
      send_point(15000000, -330000000, $urandom());
      // Bounds that normalize to a tile spanning the antimeridian.
      send_tile(2, -5000000, 5000000, 530000000, 190000000, 1'b0);
      send_point(0, 179999999, $urandom());
      send_point(5000000, -180000000, $urandom());
      send_point(-5000000, -170000000, $urandom());
      send_point(0, -169999999, $urandom());
      send_point(0, 0, $urandom());
      // South above north holds nothing, even with a full longitude span.
      send_tile(3, 5000000, -5000000, -FULL_TURN, FULL_TURN - 1, 1'b1);
      send_point(0, 100000000, $urandom());
      // Field extremes on both the tile and the point.
      send_tile(4, -134217728, 134217727, LON_RAW_MIN, LON_RAW_MAX, 1'b0);
      send_point(134217727, 0, $urandom());
      send_point(-134217728, LON_RAW_MIN, $urandom());
      send_point(LAT_LIMIT, 179000000, $urandom());

      wait_idle();
      write_allow_list(1'b1);
      send_point(15000000, 35000000, $urandom());
      send_point(0, 175000000, $urandom());
      // Rewriting an entry replaces its allowed flag as well.
      send_tile(1, 10000000, 20000000, 30000000, 40000000, 1'b0);
      send_point(15000000, 35000000, $urandom());
      send_tile(5, -LAT_LIMIT, LAT_LIMIT, -HALF_TURN, HALF_TURN - 1, 1'b1);
      send_point(-LAT_LIMIT, -HALF_TURN, $urandom());

      for (phase_num = 0; phase_num < RANDOM_PHASES; phase_num++) begin
         wait_idle();
         write_allow_list(phase_num[0]);
         item_total = $urandom_range(260, 330);
         for (item_num = 0; item_num < item_total; item_num++) begin
            if ($urandom_range(0, 99) < 35) begin
               random_tile();
            end else begin
               random_point();
            end
            // Now and then the sender holds off until every passed point is out.
            if ($urandom_range(0, 149) == 0) begin
               wait_drained();
            end
         end
      end

      release_requests();
      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (IDLE_HOLD) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d predicted passed points never came out", sb.pending());
         sb.errors = sb.errors + sb.pending();
      end

      $display("Covered %0d tile writes and %0d point tests, allow list off and on.",
               sb.tile_writes, sb.point_tests);
      $display("%0d passed points were compared, %0d mismatches seen.",
               sb.points_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Timeout waiting for the block to finish.");
      $display("Regression FAIL");
      $finish;
   end

endmodule
